// ===== src/rrts_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_pkg
// Shared types and codes for the round-robin task scheduler.
// ---------------------------------------------------------------------------
package rrts_pkg;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_RESCHED = 3'd1,
    ACT_CREATE = 3'd2,
    ACT_WAKE   = 3'd3,
    ACT_SLEEP  = 3'd4,
    ACT_EXIT   = 3'd5,
    ACT_KILL   = 3'd6,
    ACT_NONE   = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ST_NEW      = 3'd0,
    ST_RUNNABLE = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_WAITING  = 3'd3,
    ST_ZOMBIE   = 3'd4
  } slot_state_t;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT = 2'd1;
  localparam logic [1:0] STAT_NO_KILL = 2'd2;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_IDLE,
    CMD_LOAD,       // latch transaction fields, clear scan
    CMD_PRE,        // action-specific first step (tick, sleep, exit, wake)
    CMD_DEMOTE,     // demote running current, set scan start
    CMD_SCAN_SCHED, // examine one slot for scheduling
    CMD_SCHED_END,  // no runnable found: force current back
    CMD_SCAN_FREE,  // examine one slot for create
    CMD_CREATE,     // write the chosen slot
    CMD_SCAN_KILL,  // examine one slot for kill
    CMD_DONE        // drive the result
  } cmd_t;

  typedef struct packed {
    logic scan_last;   // scan counter at final slot
    logic hit_sched;   // examined slot is runnable or running
    logic hit_free;    // examined slot is free for create
    logic hit_kill;    // examined slot is the kill target
    logic pre_resched; // first step requests reschedule
    logic free_pass2;  // free scan in second pass
    logic kill_cur;    // killed slot is current
  } dp_status_t;

endpackage : rrts_pkg
`default_nettype wire

// ===== src/round_robin_task_scheduler_unit.sv =====
`default_nettype none
// A tick without reschedule, a wake or a no-op takes the shortest path (load, first
// step, result); the longest is a kill of the current task in the last slot, or a
// create that needs the second pass.
// Throughput: one transaction at a time; start is taken again in the result cycle.
// Reset (synchronous, rst_n low) returns all slots to new, clears counters
// and sets slice_length to 10. The receiver cannot stall the result.
// ---------------------------------------------------------------------------
// round_robin_task_scheduler_unit
// Task table with round-robin time-slice scheduling, one action per start.
// ---------------------------------------------------------------------------
module round_robin_task_scheduler_unit #(
  parameter int TASK_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire [2:0]   in_action,
  input  wire [3:0]   in_task_id,
  input  wire [15:0]  in_process_id,
  input  wire         in_user_task,
  input  wire [31:0]  in_exit_value,
  input  wire         cfg_we,
  input  wire [7:0]   cfg_wdata,
  output logic        out_valid,
  output logic        out_switched,
  output logic        out_has_current,
  output logic [3:0]  out_current_task,
  output logic [3:0]  out_created_task,
  output logic [1:0]  out_status,
  output logic [63:0] out_switch_total
);
  import rrts_pkg::*;

  cmd_t cmd;
  dp_status_t st;
  logic go;

  assign go = start & ~busy;

  // sequencer
  rrts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(go), .in_action(in_action),
    .st(st), .cmd(cmd), .busy(busy)
  );

  // task table datapath
  rrts_dp #(.TASK_SLOTS(TASK_SLOTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd),
    .in_action(in_action), .in_task_id(in_task_id),
    .in_process_id(in_process_id), .in_user_task(in_user_task),
    .in_exit_value(in_exit_value), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .st(st), .out_valid(out_valid), .out_switched(out_switched),
    .out_has_current(out_has_current), .out_current_task(out_current_task),
    .out_created_task(out_created_task), .out_status(out_status),
    .out_switch_total(out_switch_total)
  );

`ifndef NO_ASSERTIONS
  // a result only comes out of a transaction in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without transaction");
  // block is idle while the result is shown
  a_idle_after: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("busy after result");
  // a switch always leaves a current task
  a_switch_cur: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_switched) |-> out_has_current)
    else $error("switch without current task");
`endif

endmodule : round_robin_task_scheduler_unit
`default_nettype wire

// ===== src/rrts_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_ctrl
// Sequencer stepping one transaction through its slot scans.
// ---------------------------------------------------------------------------
module rrts_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire [2:0]           in_action,
  input  rrts_pkg::dp_status_t st,
  output rrts_pkg::cmd_t      cmd,
  output logic                busy
);
  import rrts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PRE, S_DEMOTE, S_SCHED, S_FREE, S_CREATE, S_KILL, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  action_t act_r, act_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    act_nxt = act_r;
    cmd = CMD_IDLE;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd = CMD_LOAD;
          act_nxt = action_t'(in_action);
          state_nxt = S_PRE;
        end
      end
      S_PRE: begin
        cmd = CMD_PRE;
        case (act_r)
          ACT_CREATE: state_nxt = S_FREE;
          ACT_KILL:   state_nxt = S_KILL;
          ACT_RESCHED: state_nxt = S_DEMOTE;
          default: state_nxt = st.pre_resched ? S_DEMOTE : S_DONE;
        endcase
      end
      S_DEMOTE: begin
        cmd = CMD_DEMOTE;
        state_nxt = S_SCHED;
      end
      S_SCHED: begin
        cmd = CMD_SCAN_SCHED;
        if (st.hit_sched) state_nxt = S_DONE;
        else if (st.scan_last) begin
          cmd = CMD_SCHED_END;
          state_nxt = S_DONE;
        end
      end
      S_FREE: begin
        cmd = CMD_SCAN_FREE;
        if (st.hit_free) state_nxt = S_CREATE;
        else if (st.scan_last && st.free_pass2) state_nxt = S_DONE;
      end
      S_CREATE: begin
        cmd = CMD_CREATE;
        state_nxt = S_DONE;
      end
      S_KILL: begin
        cmd = CMD_SCAN_KILL;
        if (st.hit_kill) state_nxt = st.kill_cur ? S_DEMOTE : S_DONE;
        else if (st.scan_last) state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd = CMD_DONE;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      act_r <= ACT_NONE;
    end else begin
      state_r <= state_nxt;
      act_r <= act_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule : rrts_ctrl
`default_nettype wire

// ===== src/rrts_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// rrts_dp
// Task table, current-task registers and counters; one slot per scan step.
// ---------------------------------------------------------------------------
module rrts_dp #(
  parameter int TASK_SLOTS = 16
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  rrts_pkg::cmd_t       cmd,
  input  wire [2:0]            in_action,
  input  wire [3:0]            in_task_id,
  input  wire [15:0]           in_process_id,
  input  wire                  in_user_task,
  input  wire [31:0]           in_exit_value,
  input  wire                  cfg_we,
  input  wire [7:0]            cfg_wdata,
  output rrts_pkg::dp_status_t st,
  output logic                 out_valid,
  output logic                 out_switched,
  output logic                 out_has_current,
  output logic [3:0]           out_current_task,
  output logic [3:0]           out_created_task,
  output logic [1:0]           out_status,
  output logic [63:0]          out_switch_total
);
  import rrts_pkg::*;

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

  // task table (small, one entry per slot, reset to known values)
  slot_state_t tbl_state_r [TASK_SLOTS];
  logic [15:0] tbl_pid_r   [TASK_SLOTS];
  logic        tbl_user_r  [TASK_SLOTS];
  logic [31:0] tbl_code_r  [TASK_SLOTS];
  logic [31:0] tbl_slice_r [TASK_SLOTS];
  logic        tbl_alloc_r [TASK_SLOTS];

  logic [IW-1:0] cur_r;
  logic          cur_vld_r;
  logic [7:0]    tick_r;
  logic [63:0]   swcnt_r;
  logic [7:0]    slice_len_r;

  // latched transaction
  action_t       act_r;
  logic [3:0]    tid_r;
  logic [15:0]   pid_r;
  logic          user_r;
  logic [31:0]   code_r;

  logic [IW-1:0] idx_r;     // slot under examination
  logic [IW-1:0] cnt_r;     // steps taken
  logic          pass2_r;
  logic          sw_r;
  logic [3:0]    created_r;
  logic [1:0]    stat_r;

  slot_state_t s_idx;
  logic [IW-1:0] idx_inc, cur_inc;
  logic [IW-1:0] tid_slot;
  logic [7:0] tick_inc;
  logic cur_running;
  logic wake_ok;

  assign s_idx   = tbl_state_r[idx_r];
  assign idx_inc = (idx_r == LAST) ? '0 : idx_r + 1'b1;
  assign cur_inc = (cur_r == LAST) ? '0 : cur_r + 1'b1;
  assign tick_inc = tick_r + 8'd1;
  assign cur_running = cur_vld_r && (tbl_state_r[cur_r] == ST_RUNNING);
  assign tid_slot = IW'(tid_r);
  assign wake_ok = (32'(tid_r) < 32'(TASK_SLOTS)) &&
                   (tbl_state_r[tid_slot] == ST_WAITING);

  // status to the sequencer
  always_comb begin
    st.scan_last = (cnt_r == LAST);
    st.free_pass2 = pass2_r;
    st.kill_cur = cur_vld_r && (idx_r == cur_r);
    st.pre_resched = 1'b0;
    case (act_r)
      ACT_TICK:  st.pre_resched = !(cur_running && (tick_inc < slice_len_r));
      ACT_SLEEP: st.pre_resched = cur_vld_r && !tbl_user_r[cur_r];
      ACT_EXIT:  st.pre_resched = cur_vld_r;
      default:   st.pre_resched = 1'b0;
    endcase
    st.hit_sched = (s_idx == ST_RUNNABLE) || (s_idx == ST_RUNNING);
    st.hit_free = pass2_r ? (s_idx == ST_ZOMBIE)
                  : (((s_idx == ST_ZOMBIE) || (s_idx == ST_NEW)) && !tbl_alloc_r[idx_r]);
    st.hit_kill = (pid_r != 16'd0) && (tbl_pid_r[idx_r] == pid_r) &&
                  (s_idx != ST_NEW) && (s_idx != ST_ZOMBIE);
  end

  // table and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        tbl_state_r[i] <= ST_NEW;
        tbl_pid_r[i]   <= '0;
        tbl_user_r[i]  <= 1'b0;
        tbl_code_r[i]  <= '0;
        tbl_slice_r[i] <= '0;
        tbl_alloc_r[i] <= 1'b0;
      end
      cur_r <= '0;
      cur_vld_r <= 1'b0;
      tick_r <= '0;
      swcnt_r <= '0;
      slice_len_r <= 8'd10;
      out_valid <= 1'b0;
      act_r <= ACT_NONE;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) slice_len_r <= cfg_wdata;
      case (cmd)
        CMD_LOAD: begin
          act_r <= action_t'(in_action);
          tid_r <= in_task_id;
          pid_r <= in_process_id;
          user_r <= in_user_task;
          code_r <= in_exit_value;
          sw_r <= 1'b0;
          created_r <= '0;
          stat_r <= (action_t'(in_action) == ACT_KILL) ? STAT_NO_KILL : STAT_OK;
          idx_r <= '0;
          cnt_r <= '0;
          pass2_r <= 1'b0;
        end
        CMD_PRE: begin
          case (act_r)
            ACT_TICK: tick_r <= (cur_running && (tick_inc < slice_len_r)) ? tick_inc : 8'd0;
            ACT_WAKE: if (wake_ok) tbl_state_r[tid_slot] <= ST_RUNNABLE;
            ACT_SLEEP:
              if (cur_vld_r && !tbl_user_r[cur_r]) tbl_state_r[cur_r] <= ST_WAITING;
            ACT_EXIT:
              if (cur_vld_r) begin
                tbl_code_r[cur_r] <= code_r;
                tbl_state_r[cur_r] <= ST_ZOMBIE;
              end
            default: ;
          endcase
        end
        CMD_DEMOTE: begin
          if (cur_running) tbl_state_r[cur_r] <= ST_RUNNABLE;
          idx_r <= cur_vld_r ? cur_inc : '0;
          cnt_r <= '0;
        end
        CMD_SCAN_SCHED: begin
          if (st.hit_sched) begin
            tbl_state_r[idx_r] <= ST_RUNNING;
            if (!(cur_vld_r && idx_r == cur_r)) begin
              cur_r <= idx_r;
              cur_vld_r <= 1'b1;
              tbl_slice_r[idx_r] <= tbl_slice_r[idx_r] + 32'd1;
              swcnt_r <= swcnt_r + 64'd1;
              sw_r <= 1'b1;
            end
          end else begin
            idx_r <= idx_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        CMD_SCHED_END: begin
          if (cur_vld_r) tbl_state_r[cur_r] <= ST_RUNNING;
        end
        CMD_SCAN_FREE: begin
          if (st.hit_free) begin
            if (pass2_r) tbl_alloc_r[idx_r] <= 1'b0;
          end else begin
            idx_r <= idx_inc;
            // step count restarts for the second pass
            cnt_r <= st.scan_last ? '0 : cnt_r + 1'b1;
            if (st.scan_last) begin
              if (pass2_r) stat_r <= STAT_NO_SLOT;
              pass2_r <= 1'b1;
            end
          end
        end
        CMD_CREATE: begin
          tbl_pid_r[idx_r] <= user_r ? pid_r : 16'd0;
          tbl_user_r[idx_r] <= user_r;
          tbl_alloc_r[idx_r] <= 1'b1;
          tbl_code_r[idx_r] <= '0;
          tbl_slice_r[idx_r] <= '0;
          tbl_state_r[idx_r] <= ST_RUNNABLE;
          created_r <= 4'(idx_r);
        end
        CMD_SCAN_KILL: begin
          if (st.hit_kill) begin
            stat_r <= STAT_OK;
            tbl_code_r[idx_r] <= code_r;
            tbl_state_r[idx_r] <= ST_ZOMBIE;
          end else begin
            idx_r <= idx_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        CMD_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  assign out_switched = sw_r;
  assign out_has_current = cur_vld_r;
  assign out_current_task = cur_vld_r ? 4'(cur_r) : 4'd0;
  assign out_created_task = created_r;
  assign out_status = stat_r;
  assign out_switch_total = swcnt_r;

endmodule : rrts_dp
`default_nettype wire
